@@ rtl/core/psq_pkg.sv @@
`default_nettype none

package psq_pkg;

    localparam int VAL_W  = 128;
    localparam int ROOT_W = 64;
    localparam int REM_W  = ROOT_W + 2;
    localparam int SUB_W  = REM_W + 2;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [VAL_W-1:0]  val;
    } t_cell_data;

endpackage

`default_nettype wire

@@ rtl/core/psq_cell.sv @@
`default_nettype none

module psq_cell
    import psq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_cell_data i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_cell_data      o_data
);

    logic             r_valid;
    t_cell_data       r_data;
    t_cell_data       n_data;
    logic [SUB_W-1:0] rem_sh;
    logic [SUB_W-1:0] trial;
    logic [SUB_W-1:0] diff;
    logic             take;

    always_comb begin
        rem_sh = {i_data.rem, i_data.val[VAL_W-1 -: 2]};
        trial  = {2'b00, i_data.root, 2'b01};
        take   = (rem_sh >= trial);
        diff   = rem_sh - trial;
        n_data.rem  = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        n_data.root = {i_data.root[ROOT_W-2:0], take};
        n_data.val  = {i_data.val[VAL_W-3:0], 2'b00};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_data.rem} <= {1'b0, r_data.root, 1'b0}))
        else $error("Partial remainder exceeds twice the partial root.");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_data)))
        else $error("A stalled request changed inside the cell.");

    a_low_bits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.val[1:0] == 2'b00))
        else $error("Shifted value lost its zero fill.");

endmodule

`default_nettype wire

@@ rtl/core/psq_out.sv @@
`default_nettype none

module psq_out
    import psq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_cell_data  i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [ROOT_W-1:0] o_root,
    output logic             o_found
);

    logic              r_valid;
    logic [ROOT_W-1:0] r_root;
    logic              r_found;
    logic              n_found;

    assign n_found = (i_data.rem == '0);
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_root  = r_root;
    assign o_found = r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_found <= n_found;
            r_root  <= n_found ? i_data.root : '0;
        end
    end

    a_nonsquare_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_found) |-> (r_root == '0))
        else $error("A non-square carries a nonzero root.");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_root) && $stable(r_found)))
        else $error("A stalled result changed in the output register.");

    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !$isunknown({r_root, r_found}))
        else $error("A valid result holds unknown bits.");

endmodule

`default_nettype wire

@@ rtl/core/perfect_square_test_128.sv @@
`default_nettype none

// Channel | Direction | Payload
// s_axis  | in        | tdata[63:0] value_high, tdata[127:64] value_low
// m_axis  | out       | tdata[63:0] root, tuser[0] square_found
//
// One request enters per cycle unless the whole chain is full and stalled. Each request
// passes 64 root cells and then an output register, each of which registers it.
// Each cell decides one root bit with a 68-bit compare and subtract.
// Reset is synchronous and active low and empties every stage.
// A stalled result holds in the output register while earlier stages keep
// filling their empty slots, so input stalls only when the whole chain is full.

module perfect_square_test_128
    import psq_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [127:0]  s_axis_tdata,   // value_high, value_low
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [63:0]        m_axis_tdata,   // root
    output logic [0:0]         m_axis_tuser    // square_found
);

    logic       valid_c [ROOT_W+1];
    logic       ready_c [ROOT_W+1];
    t_cell_data data_c  [ROOT_W+1];
    logic       found;

    assign valid_c[0]       = s_axis_tvalid;
    assign s_axis_tready    = ready_c[0];
    assign data_c[0].rem    = '0;
    assign data_c[0].root   = '0;
    assign data_c[0].val    = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
        psq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid_c[g]),
            .o_ready (ready_c[g]),
            .i_data  (data_c[g]),
            .o_valid (valid_c[g+1]),
            .i_ready (ready_c[g+1]),
            .o_data  (data_c[g+1])
        );
    end

    psq_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (valid_c[ROOT_W]),
        .o_ready (ready_c[ROOT_W]),
        .i_data  (data_c[ROOT_W]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_root  (m_axis_tdata),
        .o_found (found)
    );

    assign m_axis_tuser = found;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import psq_pkg::*;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              square_found;
    } t_root_answer;

    class root_scoreboard;
        t_root_answer awaited_roots[$];
        int           error_count;

        function new();
            error_count = 0;
        endfunction

        // Bit-serial floor square root, then an exact square test on the result.
        function t_root_answer predict_root(input logic [VAL_W-1:0] value);
            t_root_answer      answer;
            logic [ROOT_W-1:0] r;
            logic [ROOT_W-1:0] trial;
            logic [VAL_W-1:0]  square;
            r = '0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                trial  = r | ({{(ROOT_W-1){1'b0}}, 1'b1} << b);
                square = {{ROOT_W{1'b0}}, trial} * {{ROOT_W{1'b0}}, trial};
                if (square <= value) begin
                    r = trial;
                end
            end
            square = {{ROOT_W{1'b0}}, r} * {{ROOT_W{1'b0}}, r};
            answer.square_found = (square == value);
            answer.root         = answer.square_found ? r : '0;
            return answer;
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            error_count++;
        endtask

        function void note_request(input logic [VAL_W-1:0] value);
            awaited_roots.push_back(predict_root(value));
        endfunction

        task check_result(input logic [ROOT_W-1:0] root, input logic square_found);
            t_root_answer want;
            if (awaited_roots.size() == 0) begin
                report_mismatch($sformatf("unexpected result root=%0h flag=%0b",
                                          root, square_found));
            end else begin
                want = awaited_roots.pop_front();
                if (root !== want.root) begin
                    report_mismatch($sformatf("root %0h, want %0h", root, want.root));
                end
                if (square_found !== want.square_found) begin
                    report_mismatch($sformatf("square_found %0b, want %0b",
                                              square_found, want.square_found));
                end
            end
        endtask

        function int pending_count();
            return awaited_roots.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [127:0]       s_axis_tdata;   // value_high, value_low
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [63:0]        m_axis_tdata;   // root
    logic [0:0]         m_axis_tuser;   // square_found

    root_scoreboard sb;
    bit             sender_idles;
    bit             receiver_stalls;

    perfect_square_test_128 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        sb              = new();
    end

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request({s_axis_tdata[63:0], s_axis_tdata[127:64]});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tuser[0]);
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (receiver_stalls && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // The value is {value_high, value_low}; on the bus value_high sits in the low half.
    task automatic send_value(input logic [VAL_W-1:0] value);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value[63:0], value[127:64]};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        logic [VAL_W-1:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        return v >> $urandom_range(0, VAL_W - 1);
    endfunction

    function automatic logic [VAL_W-1:0] square_of(input logic [ROOT_W-1:0] r);
        return {{ROOT_W{1'b0}}, r} * {{ROOT_W{1'b0}}, r};
    endfunction

    function automatic logic [VAL_W-1:0] random_candidate();
        logic [ROOT_W-1:0] r;
        int                pick;
        r    = {$urandom, $urandom};
        r    = r >> $urandom_range(0, ROOT_W - 1);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            return square_of(r);
        end else if (pick < 55) begin
            return square_of(r) + VAL_W'($urandom_range(1, 3)) - VAL_W'(2);
        end else if (pick < 65) begin
            return square_of(r) + {{(ROOT_W-1){1'b0}}, r, 1'b0};
        end else begin
            return random_value();
        end
    endfunction

    initial begin
        logic [VAL_W-1:0]  directed_values[$];
        logic [ROOT_W-1:0] max_root;
        max_root = '1;
        directed_values = '{
            128'd0, 128'd1, 128'd2, 128'd3, 128'd4, 128'd8, 128'd9,
            '1,
            square_of(max_root),
            square_of(max_root) - 128'd1,
            square_of(max_root) + 128'd1,
            square_of(max_root - 64'd1) + {63'd0, max_root - 64'd1, 1'b0},
            128'd1 << 64,
            (128'd1 << 64) - 128'd1,
            128'd1 << 126,
            128'd1 << 127,
            {64'hFFFF_FFFF_FFFF_FFFF, 64'd0},
            {64'd0, 64'hFFFF_FFFF_FFFF_FFFF},
            {64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA},
            {64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555},
            square_of(64'hFFFF_FFFF),
            square_of(64'h8000_0000_0000_0001),
            square_of(64'hAAAA_AAAA_AAAA_AAAB)
        };

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_values[k]) begin
            send_value(directed_values[k]);
        end

        for (int n = 0; n < 730; n++) begin
            if (n == 300) begin
                s_axis_tvalid <= 1'b0;
                while (sb.pending_count() != 0) @(negedge i_clk);
            end
            if (n == 620) begin
                sender_idles    = 1'b0;
                receiver_stalls = 1'b0;
            end
            send_value(random_candidate());
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_count() != 0) @(negedge i_clk);
        repeat (80) @(posedge i_clk);

        if (sb.error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", sb.pending_count());
        $display("== FAIL ==");
        $finish;
    end

endmodule
